FILE: src/fpa_pkg.sv
package fpa_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int OP_WIDTH       = 3;

   localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_MIN = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_MAX = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_INC = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_DEC = 3'd7;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic                neg;
      logic                a_neg;
      logic                a_zero;
      logic                b_zero;
      logic                lt;
      logic                eq;
      logic                gt;
      logic                ovf;
   } fpa_ctl_type;

endpackage

FILE: src/fpa_front.sv
module fpa_front #(
   parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fpa_pkg::OP_WIDTH-1:0]      req_op,
   input  logic [DATA_WIDTH-1:0]             req_operand_a,
   input  logic [DATA_WIDTH-1:0]             req_operand_b,
   output logic                              out_valid,
   input  logic                              out_ready,
   output fpa_pkg::fpa_ctl_type              out_ctl,
   output logic [DATA_WIDTH-1:0]             out_r,
   output logic [DATA_WIDTH-1:0]             out_d,
   output logic [DATA_WIDTH-1:0]             out_rem,
   output logic [DATA_WIDTH+FRAC_BITS-1:0]   out_nq
);
   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
   localparam logic [2*W:0] HALF    = (2*W+1)'(1) << (F-1);

   // stage 1: operand capture
   logic                         s1_valid_ff;
   logic [fpa_pkg::OP_WIDTH-1:0] s1_op_ff;
   logic [W-1:0]                 s1_a_ff, s1_b_ff;
   // stage 2: magnitudes, product, simple ops
   logic                         s2_valid_ff;
   fpa_pkg::fpa_ctl_type         s2_ctl_ff, s2_ctl_in;
   logic [W-1:0]                 s2_r_ff, s2_r_in;
   logic [2*W-1:0]               s2_prod_ff, s2_prod_in;
   logic [W-1:0]                 s2_na_ff, s2_na_in, s2_nb_ff, s2_nb_in;
   // stage 3: product rounding, divider seed
   logic                         s3_valid_ff;
   fpa_pkg::fpa_ctl_type         s3_ctl_ff, s3_ctl_in;
   logic [W-1:0]                 s3_r_ff, s3_r_in;
   logic [W-1:0]                 s3_d_ff;
   logic [W+F-1:0]               s3_nq_ff;

   logic rdy1, rdy2, rdy3;
   logic [W:0] sum_in, dif_in, inc_in, dec_in, sel_s;
   logic       use_sat;
   logic [2*W:0] rnd, shr, lim;
   logic         msat;
   logic [W-1:0] mmag, mres;

   assign rdy3      = !s3_valid_ff || out_ready;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_stall = !rdy1;

   always_comb begin
      s2_na_in   = s1_a_ff[W-1] ? W'(-s1_a_ff) : s1_a_ff;
      s2_nb_in   = s1_b_ff[W-1] ? W'(-s1_b_ff) : s1_b_ff;
      s2_prod_in = {{W{1'b0}}, s2_na_in} * {{W{1'b0}}, s2_nb_in};
      sum_in = {s1_a_ff[W-1], s1_a_ff} + {s1_b_ff[W-1], s1_b_ff};
      dif_in = {s1_a_ff[W-1], s1_a_ff} - {s1_b_ff[W-1], s1_b_ff};
      inc_in = {s1_a_ff[W-1], s1_a_ff} + (W+1)'(1);
      dec_in = {s1_a_ff[W-1], s1_a_ff} - (W+1)'(1);
      s2_ctl_in        = '0;
      s2_ctl_in.op     = s1_op_ff;
      s2_ctl_in.a_neg  = s1_a_ff[W-1];
      s2_ctl_in.neg    = s1_a_ff[W-1] ^ s1_b_ff[W-1];
      s2_ctl_in.a_zero = (s1_a_ff == '0);
      s2_ctl_in.b_zero = (s1_b_ff == '0);
      s2_ctl_in.lt     = $signed(s1_a_ff) < $signed(s1_b_ff);
      s2_ctl_in.eq     = (s1_a_ff == s1_b_ff);
      s2_ctl_in.gt     = $signed(s1_a_ff) > $signed(s1_b_ff);
      sel_s   = sum_in;
      use_sat = 1'b0;
      s2_r_in = '0;
      unique case (s1_op_ff)
         fpa_pkg::OP_ADD: begin
            sel_s = sum_in;
            use_sat = 1'b1;
         end
         fpa_pkg::OP_SUB: begin
            sel_s = dif_in;
            use_sat = 1'b1;
         end
         fpa_pkg::OP_INC: begin
            sel_s = inc_in;
            use_sat = 1'b1;
         end
         fpa_pkg::OP_DEC: begin
            sel_s = dec_in;
            use_sat = 1'b1;
         end
         fpa_pkg::OP_MIN: s2_r_in = s2_ctl_in.gt ? s1_b_ff : s1_a_ff;
         fpa_pkg::OP_MAX: s2_r_in = s2_ctl_in.gt ? s1_a_ff : s1_b_ff;
         default: s2_r_in = '0;
      endcase
      if (use_sat) begin
         // sign bits disagree when the exact result left the range
         s2_ctl_in.ovf = sel_s[W] ^ sel_s[W-1];
         s2_r_in = s2_ctl_in.ovf ? (sel_s[W] ? MIN_VAL : MAX_VAL) : sel_s[W-1:0];
      end
   end

   always_comb begin
      rnd  = {1'b0, s2_prod_ff} + HALF;
      shr  = rnd >> F;
      lim  = (2*W+1)'(MAX_VAL) + (2*W+1)'(s2_ctl_ff.neg);
      msat = shr > lim;
      mmag = shr[W-1:0];
      mres = s2_ctl_ff.neg ? W'(-mmag) : mmag;
      s3_ctl_in = s2_ctl_ff;
      s3_r_in   = s2_r_ff;
      if (s2_ctl_ff.op == fpa_pkg::OP_MUL) begin
         s3_ctl_in.ovf = msat;
         s3_r_in = msat ? (s2_ctl_ff.neg ? MIN_VAL : MAX_VAL) : mres;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= req_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
      end
      if (rdy1) begin
         s1_op_ff <= req_op;
         s1_a_ff  <= req_operand_a;
         s1_b_ff  <= req_operand_b;
      end
      if (rdy2) begin
         s2_ctl_ff  <= s2_ctl_in;
         s2_r_ff    <= s2_r_in;
         s2_prod_ff <= s2_prod_in;
         s2_na_ff   <= s2_na_in;
         s2_nb_ff   <= s2_nb_in;
      end
      if (rdy3) begin
         s3_ctl_ff <= s3_ctl_in;
         s3_r_ff   <= s3_r_in;
         s3_d_ff   <= s2_nb_ff;
         s3_nq_ff  <= {s2_na_ff, {F{1'b0}}};
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_ctl   = s3_ctl_ff;
   assign out_r     = s3_r_ff;
   assign out_d     = s3_d_ff;
   assign out_rem   = '0;
   assign out_nq    = s3_nq_ff;

endmodule

FILE: src/fpa_div_cell.sv
module fpa_div_cell #(
   parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  fpa_pkg::fpa_ctl_type              in_ctl,
   input  logic [DATA_WIDTH-1:0]             in_r,
   input  logic [DATA_WIDTH-1:0]             in_d,
   input  logic [DATA_WIDTH-1:0]             in_rem,
   input  logic [DATA_WIDTH+FRAC_BITS-1:0]   in_nq,
   output logic                              out_valid,
   input  logic                              out_ready,
   output fpa_pkg::fpa_ctl_type              out_ctl,
   output logic [DATA_WIDTH-1:0]             out_r,
   output logic [DATA_WIDTH-1:0]             out_d,
   output logic [DATA_WIDTH-1:0]             out_rem,
   output logic [DATA_WIDTH+FRAC_BITS-1:0]   out_nq
);
   localparam int W  = DATA_WIDTH;
   localparam int QW = DATA_WIDTH + FRAC_BITS;

   logic                 valid_ff;
   fpa_pkg::fpa_ctl_type ctl_ff;
   logic [W-1:0]         r_ff, d_ff, rem_ff, rem_in;
   logic [QW-1:0]        nq_ff, nq_in;
   logic [W:0]           rem_sh, diff;
   logic                 ge;

   // one restoring step: numerator bit shifts out the top, quotient bit in the bottom
   always_comb begin
      rem_sh = {in_rem, in_nq[QW-1]};
      diff   = rem_sh - {1'b0, in_d};
      ge     = rem_sh >= {1'b0, in_d};
      rem_in = ge ? diff[W-1:0] : rem_sh[W-1:0];
      nq_in  = {in_nq[QW-2:0], ge};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         ctl_ff <= in_ctl;
         r_ff   <= in_r;
         d_ff   <= in_d;
         rem_ff <= rem_in;
         nq_ff  <= nq_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_r     = r_ff;
   assign out_d     = d_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;

endmodule

FILE: src/fpa_finish.sv
module fpa_finish #(
   parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  fpa_pkg::fpa_ctl_type              in_ctl,
   input  logic [DATA_WIDTH-1:0]             in_r,
   input  logic [DATA_WIDTH-1:0]             in_d,
   input  logic [DATA_WIDTH-1:0]             in_rem,
   input  logic [DATA_WIDTH+FRAC_BITS-1:0]   in_nq,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [DATA_WIDTH-1:0]             rsp_result,
   output logic                              rsp_a_less,
   output logic                              rsp_a_equal,
   output logic                              rsp_a_greater,
   output logic                              rsp_overflowed,
   output logic                              rsp_divide_by_zero
);
   localparam int W  = DATA_WIDTH;
   localparam int QW = DATA_WIDTH + FRAC_BITS;
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   logic         valid_ff;
   logic [W-1:0] result_ff, result_in;
   logic         lt_ff, eq_ff, gt_ff, ovf_ff, ovf_in, dz_ff, dz_in;
   logic         up;
   logic [QW:0]  qr, lim;
   logic         qsat;
   logic [W-1:0] qmag;

   always_comb begin
      // round half away from zero on the remainder
      up   = {in_rem, 1'b0} >= {1'b0, in_d};
      qr   = {1'b0, in_nq} + (QW+1)'(up);
      lim  = (QW+1)'(MAX_VAL) + (QW+1)'(in_ctl.neg);
      qsat = qr > lim;
      qmag = qr[W-1:0];
      result_in = in_r;
      ovf_in    = in_ctl.ovf;
      dz_in     = 1'b0;
      if (in_ctl.op == fpa_pkg::OP_DIV) begin
         if (in_ctl.b_zero) begin
            dz_in     = 1'b1;
            ovf_in    = !in_ctl.a_zero;
            result_in = in_ctl.a_zero ? '0 : (in_ctl.a_neg ? MIN_VAL : MAX_VAL);
         end else begin
            ovf_in    = qsat;
            result_in = qsat ? (in_ctl.neg ? MIN_VAL : MAX_VAL)
                             : (in_ctl.neg ? W'(-qmag) : qmag);
         end
      end
   end

   assign in_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         result_ff <= result_in;
         lt_ff     <= in_ctl.lt;
         eq_ff     <= in_ctl.eq;
         gt_ff     <= in_ctl.gt;
         ovf_ff    <= ovf_in;
         dz_ff     <= dz_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result         = result_ff;
   assign rsp_a_less         = lt_ff;
   assign rsp_a_equal        = eq_ff;
   assign rsp_a_greater      = gt_ff;
   assign rsp_overflowed     = ovf_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

FILE: src/fixed_point_q24_8_alu.sv
// signed fixed-point alu, raw two's complement operands with FRAC_BITS fraction bits
// request channel: req_valid/req_stall with req_op, req_operand_a, req_operand_b
// ops: add, sub, mul, div, min, max, increment a, decrement a; results saturate
// mul and div round half away from zero; div by zero sets rsp_divide_by_zero
// response channel: rsp_valid/rsp_stall with result and compare/status flags
// the pipeline is three front stages
// (capture, multiply, product rounding), one divider cell per quotient bit,
// then the output register
// one request per cycle while rsp_stall is low; all ops walk the same cell chain
// a stalled response holds in the output register; each stage refills while
// the stage after it is empty, so bubbles close up before req_stall rises
// synchronous reset empties every stage; no other state is kept
module fixed_point_q24_8_alu #(
   parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fpa_pkg::OP_WIDTH-1:0]  req_op,
   input  logic [DATA_WIDTH-1:0]         req_operand_a,
   input  logic [DATA_WIDTH-1:0]         req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DATA_WIDTH-1:0]         rsp_result,
   output logic                          rsp_a_less,
   output logic                          rsp_a_equal,
   output logic                          rsp_a_greater,
   output logic                          rsp_overflowed,
   output logic                          rsp_divide_by_zero
);
   localparam int W  = DATA_WIDTH;
   localparam int QW = DATA_WIDTH + FRAC_BITS;
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   logic                 c_valid [0:QW];
   logic                 c_ready [0:QW];
   fpa_pkg::fpa_ctl_type c_ctl   [0:QW];
   logic [W-1:0]         c_r     [0:QW];
   logic [W-1:0]         c_d     [0:QW];
   logic [W-1:0]         c_rem   [0:QW];
   logic [QW-1:0]        c_nq    [0:QW];

   fpa_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .out_valid     (c_valid[0]),
      .out_ready     (c_ready[0]),
      .out_ctl       (c_ctl[0]),
      .out_r         (c_r[0]),
      .out_d         (c_d[0]),
      .out_rem       (c_rem[0]),
      .out_nq        (c_nq[0])
   );

   for (genvar i = 0; i < QW; i++) begin : g_cell
      fpa_div_cell #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_ctl    (c_ctl[i]),
         .in_r      (c_r[i]),
         .in_d      (c_d[i]),
         .in_rem    (c_rem[i]),
         .in_nq     (c_nq[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_ctl   (c_ctl[i+1]),
         .out_r     (c_r[i+1]),
         .out_d     (c_d[i+1]),
         .out_rem   (c_rem[i+1]),
         .out_nq    (c_nq[i+1])
      );
   end

   fpa_finish #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_finish (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (c_valid[QW]),
      .in_ready           (c_ready[QW]),
      .in_ctl             (c_ctl[QW]),
      .in_r               (c_r[QW]),
      .in_d               (c_d[QW]),
      .in_rem             (c_rem[QW]),
      .in_nq              (c_nq[QW]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result         (rsp_result),
      .rsp_a_less         (rsp_a_less),
      .rsp_a_equal        (rsp_a_equal),
      .rsp_a_greater      (rsp_a_greater),
      .rsp_overflowed     (rsp_overflowed),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_equal, rsp_a_greater}))
      else $error("compare flags not exclusive");

   a_ovf_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_result == MAX_VAL || rsp_result == MIN_VAL)
      else $error("saturated result not at a bound");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_overflowed == (rsp_result != '0))
      else $error("divide by zero status mismatch");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

FILE: bench/fpa_alu_checker.sv
module fpa_alu_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_result,
   input  logic        rsp_a_less,
   input  logic        rsp_a_equal,
   input  logic        rsp_a_greater,
   input  logic        rsp_overflowed,
   input  logic        rsp_divide_by_zero,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint MAX_RAW = 64'sd2147483647;
   localparam longint MIN_RAW = -64'sd2147483648;

   typedef struct {
      logic [31:0] result;
      logic        less;
      logic        equal;
      logic        greater;
      logic        ovf;
      logic        dz;
   } alu_answer_type;

   alu_answer_type answer_q[$];

   function automatic longint clamp_signed(input longint v, inout logic ovf);
      if (v > MAX_RAW) begin
         ovf = 1'b1;
         return MAX_RAW;
      end
      if (v < MIN_RAW) begin
         ovf = 1'b1;
         return MIN_RAW;
      end
      return v;
   endfunction

   // sign and magnitude back to a saturated raw value
   function automatic longint from_magnitude(input logic neg, input logic [63:0] m,
                                             inout logic ovf);
      logic [63:0] lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > lim) begin
         ovf = 1'b1;
         return neg ? MIN_RAW : MAX_RAW;
      end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic alu_answer_type compute_answer(input logic [2:0] op,
                                                     input logic [31:0] ra,
                                                     input logic [31:0] rb);
      alu_answer_type ans;
      longint a, b, r;
      logic [63:0] ma, mb, q, rem;
      logic ovf, neg;
      a = longint'($signed(ra));
      b = longint'($signed(rb));
      ma = a < 0 ? 64'(-a) : 64'(a);
      mb = b < 0 ? 64'(-b) : 64'(b);
      neg = (a < 0) != (b < 0);
      ovf = 1'b0;
      ans.dz = 1'b0;
      case (op)
         fpa_pkg::OP_ADD: r = clamp_signed(a + b, ovf);
         fpa_pkg::OP_SUB: r = clamp_signed(a - b, ovf);
         fpa_pkg::OP_MUL: begin
            q = (ma * mb + 64'd128) >> 8;
            r = from_magnitude(neg, q, ovf);
         end
         fpa_pkg::OP_DIV: begin
            if (b == 0) begin
               ans.dz = 1'b1;
               if (a > 0) begin
                  r = MAX_RAW;
                  ovf = 1'b1;
               end else if (a < 0) begin
                  r = MIN_RAW;
                  ovf = 1'b1;
               end else begin
                  r = 0;
               end
            end else begin
               q = (ma << 8) / mb;
               rem = (ma << 8) % mb;
               // half away from zero on the magnitude
               if (rem >= mb - rem) q = q + 1;
               r = from_magnitude(neg, q, ovf);
            end
         end
         fpa_pkg::OP_MIN: r = (a <= b) ? a : b;
         fpa_pkg::OP_MAX: r = (a > b) ? a : b;
         fpa_pkg::OP_INC: r = clamp_signed(a + 1, ovf);
         default: r = clamp_signed(a - 1, ovf);
      endcase
      ans.result = r[31:0];
      ans.less = a < b;
      ans.equal = a == b;
      ans.greater = a > b;
      ans.ovf = ovf;
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      alu_answer_type want;
      if (reset) begin
         fail_count = 0;
         answer_q.delete();
      end else begin
         if (req_valid && !req_stall)
            answer_q.push_back(compute_answer(req_op, req_operand_a, req_operand_b));
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_result, 32'd0);
            end else begin
               want = answer_q.pop_front();
               if (rsp_result !== want.result)
                  report_mismatch("result", rsp_result, want.result);
               if (rsp_a_less !== want.less)
                  report_mismatch("a_less", 32'(rsp_a_less), 32'(want.less));
               if (rsp_a_equal !== want.equal)
                  report_mismatch("a_equal", 32'(rsp_a_equal), 32'(want.equal));
               if (rsp_a_greater !== want.greater)
                  report_mismatch("a_greater", 32'(rsp_a_greater), 32'(want.greater));
               if (rsp_overflowed !== want.ovf)
                  report_mismatch("overflowed", 32'(rsp_overflowed), 32'(want.ovf));
               if (rsp_divide_by_zero !== want.dz)
                  report_mismatch("divide_by_zero", 32'(rsp_divide_by_zero),
                                  32'(want.dz));
            end
         end
      end
      pending <= answer_q.size();
   end
endmodule

FILE: bench/tb_fixed_point_q24_8_alu.sv
module tb_fixed_point_q24_8_alu;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_COUNT = 1300;
   localparam int CYCLE_LIMIT = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = fpa_pkg::OP_ADD;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result;
   logic        rsp_a_less, rsp_a_equal, rsp_a_greater;
   logic        rsp_overflowed, rsp_divide_by_zero;
   int          fail_count, pending;
   int          cycles = 0;
   bit          quiet = 1'b0;

   always #5 clock = ~clock;

   fixed_point_q24_8_alu dut (.*);

   fpa_alu_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_fixed_point_q24_8_alu: FAIL");
         $finish;
      end
   end

   // response side backpressure in bursts
   always @(posedge clock) begin
      if (!reset && !quiet && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 19)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 4095)) - 32'd2048;
         3: return 32'd0;
         4: return $signed($urandom()) >>> $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(input logic [2:0] op, input logic [31:0] a,
                               input logic [31:0] b);
      req_valid <= 1'b1;
      req_op <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(fpa_pkg::OP_ADD, 32'h7fffffff, 32'h00000001);
      send_request(fpa_pkg::OP_ADD, 32'h80000000, 32'h80000000);
      send_request(fpa_pkg::OP_SUB, 32'h80000000, 32'h00000001);
      send_request(fpa_pkg::OP_SUB, 32'h7fffffff, 32'hffffffff);
      send_request(fpa_pkg::OP_MUL, 32'h00000080, 32'h00000001);   // half rounds up
      send_request(fpa_pkg::OP_MUL, 32'hffffff80, 32'h00000001);   // negative half
      send_request(fpa_pkg::OP_MUL, 32'h7fffffff, 32'h7fffffff);
      send_request(fpa_pkg::OP_MUL, 32'h80000000, 32'h00000100);
      send_request(fpa_pkg::OP_MUL, 32'h80000000, 32'hffffff00);
      send_request(fpa_pkg::OP_DIV, 32'h00000005, 32'h00000000);   // divide by zero
      send_request(fpa_pkg::OP_DIV, 32'hfffffffb, 32'h00000000);
      send_request(fpa_pkg::OP_DIV, 32'h00000000, 32'h00000000);
      send_request(fpa_pkg::OP_DIV, 32'h00000001, 32'h00000200);   // tie on remainder
      send_request(fpa_pkg::OP_DIV, 32'hffffffff, 32'h00000200);
      send_request(fpa_pkg::OP_DIV, 32'h80000000, 32'hffffff00);
      send_request(fpa_pkg::OP_DIV, 32'h7fffffff, 32'h00000001);
      send_request(fpa_pkg::OP_MIN, 32'h00001234, 32'h00001234);
      send_request(fpa_pkg::OP_MIN, 32'h80000000, 32'h7fffffff);
      send_request(fpa_pkg::OP_MAX, 32'h80000000, 32'h7fffffff);
      send_request(fpa_pkg::OP_MAX, 32'hffffffff, 32'hffffffff);
      send_request(fpa_pkg::OP_INC, 32'h7fffffff, 32'h00000000);
      send_request(fpa_pkg::OP_INC, 32'hffffffff, 32'h00000001);
      send_request(fpa_pkg::OP_DEC, 32'h80000000, 32'h00000000);
      send_request(fpa_pkg::OP_DEC, 32'h00000000, 32'hffffffff);

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT / 2) begin
            req_valid <= 1'b0;
            wait (pending == 0);
            @(posedge clock);
         end
         if (i == RANDOM_COUNT - 200) quiet = 1'b1;
         maybe_idle();
         send_request(3'($urandom_range(0, 7)), pick_operand(), pick_operand());
      end
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("tb_fixed_point_q24_8_alu: PASS");
      else
         $display("tb_fixed_point_q24_8_alu: FAIL");
      $finish;
   end
endmodule
